/* rtl/core/sds_pkg.sv */
// Package for the soliton degree sampler: widths, tdata layout and the
// sequencer microcode (control word type and program ROM).
// No dependencies.
package sds_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 11;
  localparam int ENTRY_W     = 33;
  localparam int UNIF_W      = 32;
  localparam int DEG_W       = 11;

  localparam int IDX_LSB     = 0;
  localparam int VAL_LSB     = IDX_LSB + 10;
  localparam int UNIF_LSB    = VAL_LSB + ENTRY_W;
  localparam int IN_FIELDS_W = UNIF_LSB + UNIF_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DEG_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_ENTRY_COUNT = 3'd0;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam int STEP_W = 2;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    JMP_ALWAYS   = 2'd0,
    JMP_SAMPLE   = 2'd1,
    JMP_CNT_ZERO = 2'd2,
    JMP_OUT_FREE = 2'd3
  } jump_cond_t;

  typedef struct packed {
    logic       accept;
    logic       issue_rd;
    logic       update;
    logic       emit;
    jump_cond_t cond;
    step_t      target;
  } ucode_word_t;

  localparam step_t STEP_IDLE  = 2'd0;
  localparam step_t STEP_PROBE = 2'd1;
  localparam step_t STEP_CMP   = 2'd2;
  localparam step_t STEP_EMIT  = 2'd3;

  function automatic ucode_word_t ucode_rom(input step_t step);
    ucode_word_t w;
    w = '{accept: 1'b0, issue_rd: 1'b0, update: 1'b0, emit: 1'b0,
          cond: JMP_ALWAYS, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond   = JMP_SAMPLE;
        w.target = STEP_PROBE;
      end
      STEP_PROBE: begin
        w.issue_rd = 1'b1;
        w.cond     = JMP_CNT_ZERO;
        w.target   = STEP_EMIT;
      end
      STEP_CMP: begin
        w.update = 1'b1;
        w.cond   = JMP_ALWAYS;
        w.target = STEP_PROBE;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = JMP_OUT_FREE;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/soliton_degree_sampler_unit.sv */
// Soliton degree sampler top level: cumulative table memory, binary search
// datapath driven by a microcoded step sequencer, stream and APB ports.
// Depends on sds_pkg.
// Table writes leave the sequencer in IDLE, no result. Sample: accepted in IDLE, then
// the search runs PROBE and CMP, two sequencer steps per search iteration for the
// registered table read, until the count is zero, then EMIT;
// a result waiting on out_tready holds the sequencer in EMIT, which then returns to IDLE.
// Reset (rst_n low, synchronous) clears the sequencer, output valid and sets
// the entry count to 1; the table is undefined until written, no clearing pass.
module soliton_degree_sampler_unit
  import sds_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // entry_index[9:0], entry_value[42:10], uniform_value[74:43], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // degree[10:0], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  logic [ENTRY_W-1:0] table_mem_r [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  logic [CNT_W-1:0]   entries_cfg_r;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [UNIF_W-1:0]  value_r, value_nxt;
  step_t              step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DEG_W-1:0]   degree_r, degree_nxt;

  ucode_word_t        uw;
  logic               in_fire;
  logic               wr_fire;
  logic               smp_fire;
  logic               out_free;
  logic               cfg_sel;
  logic               cfg_wr;
  logic [CNT_W-1:0]   half;
  logic [CNT_W-1:0]   probe;
  logic [CNT_W-1:0]   n_sat;

  assign uw        = ucode_rom(step_r);
  assign in_tready = uw.accept;
  assign in_fire   = in_tvalid & in_tready;
  assign wr_fire   = in_fire & (in_tuser == REQ_WRITE);
  assign smp_fire  = in_fire & (in_tuser == REQ_SAMPLE);
  assign out_free  = ~out_valid_r | out_tready;

  assign half  = {1'b0, cnt_r[CNT_W-1:1]};
  assign probe = lo_r + half;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = (cfg_paddr[CFG_ADDR_W-1:2] == CFG_ADDR_ENTRY_COUNT[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & cfg_sel;
  assign cfg_prdata = cfg_sel ? CFG_DATA_W'(entries_cfg_r) : '0;

  always_comb begin
    n_sat = entries_cfg_r;
    if (entries_cfg_r == '0) begin
      n_sat = CNT_W'(1);
    end else if (entries_cfg_r > CNT_W'(TABLE_DEPTH)) begin
      n_sat = CNT_W'(TABLE_DEPTH);
    end
  end

  always_comb begin
    case (uw.cond)
      JMP_ALWAYS:   step_nxt = uw.target;
      JMP_SAMPLE:   step_nxt = smp_fire ? uw.target : step_r;
      JMP_CNT_ZERO: step_nxt = (cnt_r == '0) ? uw.target : step_r + STEP_W'(1);
      JMP_OUT_FREE: step_nxt = out_free ? uw.target : step_r;
      default:      step_nxt = STEP_IDLE;
    endcase
  end

  always_comb begin
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    cnt_nxt       = cnt_r;
    value_nxt     = value_r;
    degree_nxt    = degree_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    if (uw.accept && smp_fire) begin
      value_nxt = in_tdata[UNIF_LSB +: UNIF_W];
      lo_nxt    = '0;
      cnt_nxt   = n_sat;
      n_nxt     = n_sat;
    end
    if (uw.update) begin
      if (rdata_r < {1'b0, value_r}) begin
        lo_nxt  = probe + CNT_W'(1);
        cnt_nxt = cnt_r - half - CNT_W'(1);
      end else begin
        cnt_nxt = half;
      end
    end
    if (uw.emit && out_free) begin
      out_valid_nxt = 1'b1;
      degree_nxt    = (lo_r < n_r) ? DEG_W'(lo_r + CNT_W'(1)) : DEG_W'(n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      table_mem_r[in_tdata[IDX_LSB +: ADDR_W]] <= in_tdata[VAL_LSB +: ENTRY_W];
    end
    if (uw.issue_rd) begin
      rdata_r <= table_mem_r[probe[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r        <= STEP_IDLE;
      out_valid_r   <= 1'b0;
      entries_cfg_r <= CNT_W'(1);
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        entries_cfg_r <= cfg_pwdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    lo_r     <= lo_nxt;
    cnt_r    <= cnt_nxt;
    value_r  <= value_nxt;
    degree_r <= degree_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(degree_r);

endmodule
